/* design/hslrgb_pkg.sv */
// Shared constants, types and fixed-point scaling figures for the HSL to RGB converter.
// Depends on nothing; every other design file imports it.
package hslrgb_pkg;

    // Output channel width and full-scale channel value
    localparam int CHANNEL_BITS = 8;
    localparam int OMAX         = (1 << CHANNEL_BITS) - 1;
    localparam int NUM_CH       = 3;

    // Input field widths and fixed-point scale
    localparam int HUE_BITS   = 9;
    localparam int FRAC_BITS  = 8;
    localparam int FRAC_ONE   = 255;
    localparam int HUE_FULL   = 360;
    localparam int HUE_SECTOR = 60;
    localparam int TRI_BITS   = 6;
    localparam int CN_BITS    = 2 * FRAC_BITS;

    // Terms are kept over half the common denominator 120*255*255
    localparam longint unsigned DEN_H = 64'(2 * HUE_SECTOR * FRAC_ONE * FRAC_ONE / 2);
    localparam int N_BITS = $clog2(DEN_H + 1);
    localparam int M_L    = FRAC_ONE * HUE_SECTOR;   // lightness weight
    localparam int M_C    = HUE_SECTOR / 2;          // chroma weight in the offset
    localparam int S_BITS = N_BITS + 2;              // signed term plus offset sum

    // Scaling t = n*OMAX + DEN_H/2, then q = t / DEN_H by reciprocal plus one correction
    localparam longint unsigned TMAX   = DEN_H * 64'(OMAX) + DEN_H / 2;
    localparam int              T_BITS = $clog2(TMAX + 1);
    localparam longint unsigned RECIP  = (64'd1 << T_BITS) / DEN_H;
    localparam int              R_BITS = $clog2(RECIP + 1);
    localparam int              P_BITS = T_BITS + R_BITS;
    localparam int              Q_BITS = CHANNEL_BITS + 1;
    localparam int              D_BITS = T_BITS + 1;

    // Stream data widths, padded to whole bytes
    localparam int IN_W  = ((HUE_BITS + 2 * FRAC_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((NUM_CH * CHANNEL_BITS + 7) / 8) * 8;

    // 60-degree hue sectors
    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } t_sector;

    typedef logic [N_BITS-1:0]       t_num;
    typedef logic [CHANNEL_BITS-1:0] t_chan;

    // Decoded pixel handed from the chroma stages to the term stages
    typedef struct packed {
        t_sector              sector;
        logic [TRI_BITS-1:0]  ramp;
        logic [CN_BITS-1:0]   cn;
        logic [FRAC_BITS-1:0] l;
    } t_prep;

endpackage

/* design/hsl_to_rgb_converter.sv */
// Top level of the HSL to RGB converter: stream ports and the three pipeline sections.
// Depends on hslrgb_pkg, hslrgb_prep, hslrgb_terms and hslrgb_scale.
//
//  channel   direction  handshake                          payload
//  s_axis    in         i_s_axis_tvalid / o_s_axis_tready  hue, saturation, lightness
//  m_axis    out        o_m_axis_tvalid / i_m_axis_tready  red, green, blue
//
// One pixel per clock sustained while the output is not stalled; each pixel passes through the
// eight register stages (decode, chroma, terms, sum, scale, reciprocal multiply, back-multiply,
// correction) to the output register. Synchronous active-low reset clears valid bits only.
// Each stage holds while its successor is full and stalled, so bubbles close up and a
// request waiting at the output does not stop new pixels entering emptier stages.
module hsl_to_rgb_converter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // [8:0] hue, [16:9] saturation, [24:17] lightness, rest zero
    input  logic [hslrgb_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [hslrgb_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import hslrgb_pkg::*;

    logic               w_prep_vld, w_terms_rdy;
    logic               w_terms_vld, w_scale_rdy;
    t_prep              w_prep;
    t_num [NUM_CH-1:0]  w_num;
    t_chan [NUM_CH-1:0] w_chan;

    // hue decode and chroma
    hslrgb_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_s_axis_tvalid),
        .o_rdy   (o_s_axis_tready),
        .i_hue   (i_s_axis_tdata[HUE_BITS-1:0]),
        .i_sat   (i_s_axis_tdata[HUE_BITS +: FRAC_BITS]),
        .i_light (i_s_axis_tdata[HUE_BITS+FRAC_BITS +: FRAC_BITS]),
        .o_vld   (w_prep_vld),
        .i_rdy   (w_terms_rdy),
        .o_data  (w_prep)
    );

    // C, X, M and sector placement
    hslrgb_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_prep_vld),
        .o_rdy   (w_terms_rdy),
        .i_data  (w_prep),
        .o_vld   (w_terms_vld),
        .i_rdy   (w_scale_rdy),
        .o_num   (w_num)
    );

    // scaling to channel range, holds the output register
    hslrgb_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_terms_vld),
        .o_rdy   (w_scale_rdy),
        .i_num   (w_num),
        .o_vld   (o_m_axis_tvalid),
        .i_rdy   (i_m_axis_tready),
        .o_chan  (w_chan)
    );

    assign o_m_axis_tdata = OUT_W'(w_chan);

endmodule

/* design/hslrgb_prep.sv */
// Stages 1-2: hue wrap, sector and ramp decode, then chroma numerator (1-|2L-1|)*S.
// Depends on hslrgb_pkg.
module hslrgb_prep (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    output logic                           o_rdy,
    input  logic [hslrgb_pkg::HUE_BITS-1:0]  i_hue,
    input  logic [hslrgb_pkg::FRAC_BITS-1:0] i_sat,
    input  logic [hslrgb_pkg::FRAC_BITS-1:0] i_light,
    output logic                           o_vld,
    input  logic                           i_rdy,
    output hslrgb_pkg::t_prep              o_data
);
    import hslrgb_pkg::*;

    logic                 w_en1, w_en2;
    logic                 r_vld1, r_vld2;
    logic [HUE_BITS-1:0]  w_hw;
    logic [HUE_BITS-1:0]  w_hm;
    t_sector              n_sec, r_sec1;
    logic [TRI_BITS-1:0]  n_tri, r_tri1;
    logic [FRAC_BITS-1:0] n_dl, r_dl1;
    logic [FRAC_BITS-1:0] r_s1, r_l1;
    t_prep                n_out, r_out;

    // stall chain
    assign w_en2 = !r_vld2 || i_rdy;
    assign w_en1 = !r_vld1 || w_en2;
    assign o_rdy = w_en1;

    // stage 1: hue decode and lightness distance
    always_comb begin
        w_hw = (i_hue >= HUE_BITS'(HUE_FULL)) ? i_hue - HUE_BITS'(HUE_FULL) : i_hue;
        if (w_hw < HUE_BITS'(HUE_SECTOR)) begin
            n_sec = SEC_R_TO_Y;
        end else if (w_hw < HUE_BITS'(2 * HUE_SECTOR)) begin
            n_sec = SEC_Y_TO_G;
        end else if (w_hw < HUE_BITS'(3 * HUE_SECTOR)) begin
            n_sec = SEC_G_TO_C;
        end else if (w_hw < HUE_BITS'(4 * HUE_SECTOR)) begin
            n_sec = SEC_C_TO_B;
        end else if (w_hw < HUE_BITS'(5 * HUE_SECTOR)) begin
            n_sec = SEC_B_TO_M;
        end else begin
            n_sec = SEC_M_TO_R;
        end
        // position within the 120-degree period
        if (w_hw < HUE_BITS'(2 * HUE_SECTOR)) begin
            w_hm = w_hw;
        end else if (w_hw < HUE_BITS'(4 * HUE_SECTOR)) begin
            w_hm = w_hw - HUE_BITS'(2 * HUE_SECTOR);
        end else begin
            w_hm = w_hw - HUE_BITS'(4 * HUE_SECTOR);
        end
        // triangle ramp 60 - |hm - 60|
        n_tri = (w_hm < HUE_BITS'(HUE_SECTOR)) ? TRI_BITS'(w_hm)
                : TRI_BITS'(HUE_BITS'(2 * HUE_SECTOR) - w_hm);
        // 255 - |2L - 255|
        n_dl = i_light[FRAC_BITS-1] ? FRAC_BITS'(10'(2 * FRAC_ONE) - {i_light, 1'b0})
               : {i_light[FRAC_BITS-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (w_en1) begin
            r_vld1 <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_sec1 <= n_sec;
            r_tri1 <= n_tri;
            r_dl1  <= n_dl;
            r_s1   <= i_sat;
            r_l1   <= i_light;
        end
    end

    // stage 2: chroma numerator over 255*255
    always_comb begin
        n_out.sector = r_sec1;
        n_out.ramp   = r_tri1;
        n_out.cn     = CN_BITS'(r_dl1) * CN_BITS'(r_s1);
        n_out.l      = r_l1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else if (w_en2) begin
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_out <= n_out;
        end
    end

    assign o_vld  = r_vld2;
    assign o_data = r_out;

    // ramp never exceeds one sector
    a_tri_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld1 |-> (r_tri1 <= TRI_BITS'(HUE_SECTOR)))
        else $error("hue ramp above one sector");

endmodule

/* design/hslrgb_terms.sv */
// Stages 3-4: C, X and M terms over the half denominator, then sector placement and sum.
// Depends on hslrgb_pkg.
module hslrgb_terms (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_vld,
    output logic                                       o_rdy,
    input  hslrgb_pkg::t_prep                          i_data,
    output logic                                       o_vld,
    input  logic                                       i_rdy,
    output hslrgb_pkg::t_num [hslrgb_pkg::NUM_CH-1:0]  o_num
);
    import hslrgb_pkg::*;

    logic                      w_en3, w_en4;
    logic                      r_vld3, r_vld4;
    t_num                      n_c, n_x, r_c3, r_x3;
    logic signed [N_BITS:0]    n_m, r_m3;
    t_sector                   r_sec3;
    t_num [NUM_CH-1:0]         w_v;
    logic signed [S_BITS-1:0]  w_sum [NUM_CH];
    t_num [NUM_CH-1:0]         n_num, r_num;

    // stall chain
    assign w_en4 = !r_vld4 || i_rdy;
    assign w_en3 = !r_vld3 || w_en4;
    assign o_rdy = w_en3;

    // stage 3: the three terms
    always_comb begin
        n_c = N_BITS'(32'(i_data.cn) * HUE_SECTOR);
        n_x = N_BITS'(i_data.cn) * N_BITS'(i_data.ramp);
        n_m = $signed({1'b0, N_BITS'(32'(i_data.l) * M_L)})
            - $signed({1'b0, N_BITS'(32'(i_data.cn) * M_C)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else if (w_en3) begin
            r_vld3 <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_c3   <= n_c;
            r_x3   <= n_x;
            r_m3   <= n_m;
            r_sec3 <= i_data.sector;
        end
    end

    // stage 4: place C and X by sector, add offset, clamp to 0..1
    always_comb begin
        case (r_sec3)
            SEC_R_TO_Y: w_v = {t_num'(0), r_x3, r_c3};
            SEC_Y_TO_G: w_v = {t_num'(0), r_c3, r_x3};
            SEC_G_TO_C: w_v = {r_x3, r_c3, t_num'(0)};
            SEC_C_TO_B: w_v = {r_c3, r_x3, t_num'(0)};
            SEC_B_TO_M: w_v = {r_c3, t_num'(0), r_x3};
            SEC_M_TO_R: w_v = {r_x3, t_num'(0), r_c3};
            default:    w_v = {r_x3, t_num'(0), r_c3};
        endcase
        for (int k = 0; k < NUM_CH; k++) begin
            w_sum[k] = $signed({2'b00, w_v[k]}) + S_BITS'(r_m3);
            if (w_sum[k] < 0) begin
                n_num[k] = '0;
            end else if (w_sum[k] > $signed(S_BITS'(DEN_H))) begin
                n_num[k] = N_BITS'(DEN_H);
            end else begin
                n_num[k] = N_BITS'(w_sum[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else if (w_en4) begin
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_num <= n_num;
        end
    end

    assign o_vld = r_vld4;
    assign o_num = r_num;

    // offset L - C/2 is never negative for any S and L
    a_m_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld3 |-> !r_m3[N_BITS])
        else $error("negative lightness offset");

endmodule

/* design/hslrgb_scale.sv */
// Stages 5-8: per-channel scaling to 0..OMAX with round half up, via reciprocal multiply
// and one remainder correction. Depends on hslrgb_pkg.
module hslrgb_scale (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_vld,
    output logic                                       o_rdy,
    input  hslrgb_pkg::t_num [hslrgb_pkg::NUM_CH-1:0]  i_num,
    output logic                                       o_vld,
    input  logic                                       i_rdy,
    output hslrgb_pkg::t_chan [hslrgb_pkg::NUM_CH-1:0] o_chan
);
    import hslrgb_pkg::*;

    logic                     w_en5, w_en6, w_en7, w_en8;
    logic                     r_vld5, r_vld6, r_vld7, r_vld8;
    logic [T_BITS-1:0]        n_t   [NUM_CH];
    logic [T_BITS-1:0]        r_t5  [NUM_CH];
    logic [T_BITS-1:0]        r_t6  [NUM_CH];
    logic [T_BITS-1:0]        r_t7  [NUM_CH];
    logic [P_BITS-1:0]        n_p   [NUM_CH];
    logic [P_BITS-1:0]        r_p6  [NUM_CH];
    logic [Q_BITS-1:0]        n_q0  [NUM_CH];
    logic [Q_BITS-1:0]        r_q7  [NUM_CH];
    logic [D_BITS-1:0]        n_dq  [NUM_CH];
    logic [D_BITS-1:0]        r_dq7 [NUM_CH];
    logic [D_BITS-1:0]        w_rem [NUM_CH];
    logic [Q_BITS-1:0]        w_q   [NUM_CH];
    logic [NUM_CH-1:0]        w_lo_ok, w_hi_ok;
    t_chan [NUM_CH-1:0]       n_out, r_out;

    // stall chain
    assign w_en8 = !r_vld8 || i_rdy;
    assign w_en7 = !r_vld7 || w_en8;
    assign w_en6 = !r_vld6 || w_en7;
    assign w_en5 = !r_vld5 || w_en6;
    assign o_rdy = w_en5;

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
            r_vld7 <= 1'b0;
            r_vld8 <= 1'b0;
        end else begin
            if (w_en5) r_vld5 <= i_vld;
            if (w_en6) r_vld6 <= r_vld5;
            if (w_en7) r_vld7 <= r_vld6;
            if (w_en8) r_vld8 <= r_vld7;
        end
    end

    // datapath: t = n*OMAX + DEN_H/2, product with reciprocal, back-multiply, correct
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            n_t[k]  = T_BITS'((D_BITS'(i_num[k]) << CHANNEL_BITS) - D_BITS'(i_num[k])
                      + D_BITS'(DEN_H / 2));
            n_p[k]  = P_BITS'(r_t5[k]) * P_BITS'(RECIP);
            n_q0[k] = Q_BITS'(r_p6[k] >> T_BITS);
            n_dq[k] = D_BITS'(n_q0[k]) * D_BITS'(DEN_H);
            // remainder lies in [0, 2*DEN_H) so one step fixes the estimate
            w_rem[k]   = D_BITS'(r_t7[k]) - r_dq7[k];
            w_lo_ok[k] = D_BITS'(r_t7[k]) >= r_dq7[k];
            w_hi_ok[k] = w_rem[k] < D_BITS'(2 * DEN_H);
            w_q[k]     = (w_rem[k] >= D_BITS'(DEN_H)) ? r_q7[k] + Q_BITS'(1) : r_q7[k];
            n_out[k]   = (w_q[k] > Q_BITS'(OMAX)) ? t_chan'(OMAX) : t_chan'(w_q[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_CH; k++) begin
            if (w_en5) begin
                r_t5[k] <= n_t[k];
            end
            if (w_en6) begin
                r_p6[k] <= n_p[k];
                r_t6[k] <= r_t5[k];
            end
            if (w_en7) begin
                r_q7[k]  <= n_q0[k];
                r_dq7[k] <= n_dq[k];
                r_t7[k]  <= r_t6[k];
            end
        end
        if (w_en8) begin
            r_out <= n_out;
        end
    end

    assign o_vld  = r_vld8;
    assign o_chan = r_out;

    // reciprocal estimate never overshoots the true quotient
    a_est_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld7 |-> (&w_lo_ok))
        else $error("quotient estimate too large");

    // reciprocal estimate is at most one below the true quotient
    a_est_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld7 |-> (&w_hi_ok))
        else $error("quotient estimate more than one low");

endmodule
